FILE: src/cric_pkg.sv
// ----------------------------------------------------------------------------
// cric_pkg
// Shared constants and types for the csg ray interval combiner
// ----------------------------------------------------------------------------
package cric_pkg;

    localparam int MAX_OBJECTS_DEF = 16;
    localparam int DIST_WIDTH_DEF  = 32;
    localparam int OBJ_W           = 7;
    localparam int TINY_W          = 16;
    localparam logic [TINY_W-1:0] TINY_RESET = 16'd1;

    // outcome of testing one complement against the current span
    typedef struct packed {
        logic take_entry;
        logic take_exit;
        logic fork_span;
        logic fail;
    } t_step_dec;

endpackage

FILE: src/cric_step.sv
// ----------------------------------------------------------------------------
// cric_step
// Compares one stored complement with the current span and decides the edit
// ----------------------------------------------------------------------------
module cric_step #(
    parameter int DIST_WIDTH = cric_pkg::DIST_WIDTH_DEF
) (
    input  logic signed [DIST_WIDTH-1:0]   i_cur_entry,
    input  logic signed [DIST_WIDTH-1:0]   i_cur_exit,
    input  logic signed [DIST_WIDTH-1:0]   i_comp_entry,
    input  logic signed [DIST_WIDTH-1:0]   i_comp_exit,
    input  logic [cric_pkg::TINY_W-1:0]    i_tiny,
    output cric_pkg::t_step_dec            o_dec
);
    localparam int CW = DIST_WIDTH + cric_pkg::TINY_W;

    logic covers;
    logic a_hit;
    logic b_hit;
    logic c_hit;
    logic px_lt_tiny;

    // exit below tiny, done in a width that holds both ranges
    assign px_lt_tiny = i_comp_exit[DIST_WIDTH-1] ||
        (CW'(unsigned'(i_comp_exit)) < CW'(i_tiny));
    assign covers = px_lt_tiny && (i_cur_entry < 0);
    assign a_hit  = covers || ((i_comp_exit < i_cur_entry) && (i_comp_entry > i_cur_entry));
    assign b_hit  = (i_comp_exit < i_cur_exit) && (i_comp_entry > i_cur_exit);
    assign c_hit  = (i_comp_exit > i_cur_entry) && (i_comp_entry < i_cur_exit);

    always_comb begin
        o_dec = '0;
        if (a_hit) begin
            o_dec.fail       = i_comp_entry > i_cur_exit;
            o_dec.take_entry = !(i_comp_entry > i_cur_exit);
        end else if (b_hit) begin
            o_dec.fail      = covers || (i_comp_exit < i_cur_entry);
            o_dec.take_exit = !(covers || (i_comp_exit < i_cur_entry));
        end else if (c_hit) begin
            o_dec.fork_span = 1'b1;
        end
    end

endmodule

FILE: src/csg_ray_interval_combiner_unit.sv
// The last segment of a ray goes straight to ST_FIN on a miss found while loading, else
// through ST_RD to ST_FIN when there are no complements; each complement test passes ST_RD,
// which registers the complement memory read, then ST_EV, and each stack pop passes ST_POP
// and ST_POPW; a new segment is taken every cycle while a ray loads, a last segment only
// while the result output is not stalled, and none during the walk
// reset: synchronous active low, clears the ray state and output valid, r_tiny to 1
// ----------------------------------------------------------------------------
// csg_ray_interval_combiner_unit
// Intersects child ray segments, then subtracts stored complements with a fork stack
// ----------------------------------------------------------------------------
module csg_ray_interval_combiner_unit #(
    parameter int MAX_OBJECTS = cric_pkg::MAX_OBJECTS_DEF,
    parameter int DIST_WIDTH  = cric_pkg::DIST_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cric_pkg::TINY_W-1:0]   i_cfg_wr_data,
    input  logic                          i_seg_valid,
    output logic                          o_seg_stall,
    input  logic signed [DIST_WIDTH-1:0]  i_seg_entry,
    input  logic signed [DIST_WIDTH-1:0]  i_seg_exit,
    input  logic                          i_last_object,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic                          o_miss,
    output logic signed [DIST_WIDTH-1:0]  o_hit_entry,
    output logic signed [DIST_WIDTH-1:0]  o_hit_exit,
    output logic signed [cric_pkg::OBJ_W-1:0] o_hit_object
);
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int OW = cric_pkg::OBJ_W;
    localparam int MW = 2 * DIST_WIDTH + OW;
    localparam int SW = 2 * DIST_WIDTH + 2 * OW + CW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OBJECTS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EV   = 3'd2;
    localparam logic [2:0] ST_POP  = 3'd3;
    localparam logic [2:0] ST_POPW = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]                  r_state;
    logic [cric_pkg::TINY_W-1:0] r_tiny;
    logic signed [DIST_WIDTH-1:0] r_en, r_ex;
    logic signed [OW-1:0]        r_ei, r_xi;
    logic [CW-1:0]               r_cnt, r_ccnt, r_x, r_sp;
    logic                        r_missed;
    logic                        r_fin_miss;
    logic [MW-1:0]               r_comp_mem [MAX_OBJECTS];
    logic [SW-1:0]               r_stack    [MAX_OBJECTS];
    logic [MW-1:0]               r_comp_q;
    logic [SW-1:0]               r_stack_q;
    logic                        r_out_valid;
    logic                        r_o_miss;
    logic signed [DIST_WIDTH-1:0] r_o_en, r_o_ex;
    logic signed [OW-1:0]        r_o_obj;

    logic                        out_busy;
    logic                        seg_acc;
    logic                        active;
    logic                        seg_behind, seg_comp;
    logic signed [DIST_WIDTH-1:0] n_en, n_ex;
    logic signed [OW-1:0]        n_ei, n_xi;
    logic                        n_missed;
    logic signed [DIST_WIDTH-1:0] q_pe, q_px;
    logic signed [OW-1:0]        q_id;
    logic [CW-1:0]               x_inc;
    cric_pkg::t_step_dec         dec;

    assign out_busy    = r_out_valid && i_res_stall;
    assign o_seg_stall = (r_state != ST_IDLE) || (i_last_object && out_busy);
    assign seg_acc     = i_seg_valid && !o_seg_stall;

    assign o_res_valid  = r_out_valid;
    assign o_miss       = r_o_miss;
    assign o_hit_entry  = r_o_en;
    assign o_hit_exit   = r_o_ex;
    assign o_hit_object = r_o_obj;

    assign q_pe  = r_comp_q[MW-1 -: DIST_WIDTH];
    assign q_px  = r_comp_q[OW +: DIST_WIDTH];
    assign q_id  = r_comp_q[OW-1:0];
    assign x_inc = r_x + 1'b1;

    // running intersection for the incoming segment
    always_comb begin
        active     = !r_missed && (r_cnt < MAX_CNT);
        seg_behind = (i_seg_entry < 0) && (i_seg_exit < 0);
        seg_comp   = i_seg_exit < i_seg_entry;
        n_en       = r_en;
        n_ex       = r_ex;
        n_ei       = r_ei;
        n_xi       = r_xi;
        n_missed   = r_missed;
        if (active) begin
            if (seg_behind) begin
                n_missed = 1'b1;
            end else if (!seg_comp) begin
                if (i_seg_entry >= 0 && i_seg_entry > r_en) begin
                    n_en = i_seg_entry;
                    n_ei = OW'(r_cnt);
                end
                if (i_seg_exit >= 0 && (r_ex < 0 || i_seg_exit < r_ex)) begin
                    n_ex = i_seg_exit;
                    n_xi = OW'(r_cnt);
                end
                if (n_en >= 0 && n_ex >= 0 && n_ex <= n_en) begin
                    n_missed = 1'b1;
                end
            end
        end
    end

    cric_step #(
        .DIST_WIDTH(DIST_WIDTH)
    ) u_step (
        .i_cur_entry (r_en),
        .i_cur_exit  (r_ex),
        .i_comp_entry(q_pe),
        .i_comp_exit (q_px),
        .i_tiny      (r_tiny),
        .o_dec       (dec)
    );

    // complement store and fork stack
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && seg_acc && active && !seg_behind && seg_comp) begin
            r_comp_mem[r_ccnt[AW-1:0]] <= {i_seg_entry, i_seg_exit, OW'(r_cnt)};
        end
        if (r_state == ST_RD) begin
            r_comp_q <= r_comp_mem[r_x[AW-1:0]];
        end
        if (r_state == ST_EV && dec.fork_span && r_sp < MAX_CNT) begin
            r_stack[r_sp[AW-1:0]] <= {q_pe, r_ex, q_id, r_xi, x_inc};
        end
        if (r_state == ST_POP) begin
            r_stack_q <= r_stack[AW'(r_sp - 1'b1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tiny      <= cric_pkg::TINY_RESET;
            r_en        <= '1;
            r_ex        <= '1;
            r_ei        <= '1;
            r_xi        <= '1;
            r_cnt       <= '0;
            r_ccnt      <= '0;
            r_x         <= '0;
            r_sp        <= '0;
            r_missed    <= 1'b0;
            r_fin_miss  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tiny <= i_cfg_wr_data;
            end
            // in ST_FIN the valid is set again below whenever the output is free
            if (r_out_valid && !i_res_stall && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (seg_acc) begin
                        r_en     <= n_en;
                        r_ex     <= n_ex;
                        r_ei     <= n_ei;
                        r_xi     <= n_xi;
                        r_missed <= n_missed;
                        if (active) begin
                            r_cnt <= r_cnt + 1'b1;
                            if (!seg_behind && seg_comp) begin
                                r_ccnt <= r_ccnt + 1'b1;
                            end
                        end
                        if (i_last_object) begin
                            r_x        <= '0;
                            r_sp       <= '0;
                            r_fin_miss <= n_missed || (n_ex < 0);
                            r_state    <= (n_missed || n_ex < 0) ? ST_FIN : ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    if (r_x >= r_ccnt) begin
                        r_fin_miss <= 1'b0;
                        r_state    <= ST_FIN;
                    end else begin
                        r_state <= ST_EV;
                    end
                end
                ST_EV: begin
                    if (dec.fail) begin
                        if (r_sp == '0) begin
                            r_fin_miss <= 1'b1;
                            r_state    <= ST_FIN;
                        end else begin
                            r_state <= ST_POP;
                        end
                    end else if (dec.fork_span) begin
                        // front part goes on at the same complement
                        r_state <= ST_RD;
                        if (r_sp < MAX_CNT) begin
                            r_sp <= r_sp + 1'b1;
                        end
                        r_ex <= q_px;
                        r_xi <= q_id;
                    end else begin
                        r_state <= ST_RD;
                        if (dec.take_entry) begin
                            r_en <= q_pe;
                            r_ei <= q_id;
                        end
                        if (dec.take_exit) begin
                            r_ex <= q_px;
                            r_xi <= q_id;
                        end
                        r_x <= x_inc;
                    end
                end
                ST_POP: begin
                    r_sp    <= r_sp - 1'b1;
                    r_state <= ST_POPW;
                end
                ST_POPW: begin
                    r_en    <= r_stack_q[SW-1 -: DIST_WIDTH];
                    r_ex    <= r_stack_q[SW-1-DIST_WIDTH -: DIST_WIDTH];
                    r_ei    <= r_stack_q[CW+OW +: OW];
                    r_xi    <= r_stack_q[CW +: OW];
                    r_x     <= r_stack_q[CW-1:0];
                    r_state <= ST_RD;
                end
                ST_FIN: begin
                    if (!out_busy) begin
                        r_out_valid <= 1'b1;
                        r_o_miss    <= r_fin_miss;
                        r_o_en      <= r_fin_miss ? '1 : r_en;
                        r_o_ex      <= r_fin_miss ? '1 : r_ex;
                        r_o_obj     <= r_fin_miss ? '1 : ((r_en < 0) ? r_xi : r_ei);
                        r_en        <= '1;
                        r_ex        <= '1;
                        r_ei        <= '1;
                        r_xi        <= '1;
                        r_cnt       <= '0;
                        r_ccnt      <= '0;
                        r_missed    <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ccnt <= r_cnt) && (r_cnt <= MAX_CNT))
        else $error("complement count beyond segment count");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= MAX_CNT)
        else $error("fork stack overflow");

    a_ev_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EV) |-> (r_x < r_ccnt))
        else $error("complement test past stored count");

    a_fin_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !out_busy) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not delivered after walk");

endmodule
